@@ sv/bvcp_pkg.sv @@
`default_nettype none

package bvcp_pkg;

  // field widths
  localparam int MV_W  = 16;
  localparam int PCT_W = 7;

  // full-charge value and curve storage
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam int TABLE_SLOTS = 64;

  // numerator of the rounded division: offset * rise + half span
  localparam int NUM_W = MV_W + PCT_W;
  // reciprocal scale, one bit above the numerator keeps the quotient error below one
  localparam int RCP_SHIFT = NUM_W + 1;
  localparam int RCP_W = RCP_SHIFT + 1;

  // pipeline depth, output register included
  localparam int STAGES = 7;

  // result selection codes
  localparam logic [1:0] CLS_SEG   = 2'd0;
  localparam logic [1:0] CLS_FULL  = 2'd1;
  localparam logic [1:0] CLS_EMPTY = 2'd2;
  localparam logic [1:0] CLS_FLAT  = 2'd3;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } curve_point_t;

  // descending open-circuit voltage curve of a 4.2 V lithium-polymer cell
  localparam curve_point_t OCV_TABLE [TABLE_SLOTS] = '{
    0:  '{16'd4200, 7'd100},
    1:  '{16'd4150, 7'd95},
    2:  '{16'd4110, 7'd90},
    3:  '{16'd4080, 7'd85},
    4:  '{16'd4020, 7'd80},
    5:  '{16'd3980, 7'd75},
    6:  '{16'd3950, 7'd70},
    7:  '{16'd3910, 7'd65},
    8:  '{16'd3870, 7'd60},
    9:  '{16'd3850, 7'd55},
    10: '{16'd3840, 7'd50},
    11: '{16'd3820, 7'd45},
    12: '{16'd3800, 7'd40},
    13: '{16'd3790, 7'd35},
    14: '{16'd3770, 7'd30},
    15: '{16'd3750, 7'd25},
    16: '{16'd3730, 7'd20},
    17: '{16'd3710, 7'd16},
    18: '{16'd3690, 7'd13},
    19: '{16'd3610, 7'd10},
    20: '{16'd3520, 7'd7},
    21: '{16'd3420, 7'd5},
    22: '{16'd3300, 7'd3},
    23: '{16'd3000, 7'd0},
    default: '0
  };

endpackage

`default_nettype wire

@@ sv/battery_voltage_to_charge_percent.sv @@
// throughput: one word per cycle while the output does not stall;
// seven register stages with a valid bit each, the widest being the numerator
// by reciprocal multiply
// a stall on the output holds every full stage, empty stages still fill
// reset: synchronous, active high, clears the valid bits only
`default_nettype none

module battery_voltage_to_charge_percent
  import bvcp_pkg::*;
#(
  parameter int CURVE_POINTS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             voltage_valid,
  output logic                  voltage_ready,
  input  wire logic [MV_W-1:0]  voltage_mv,
  output logic                  charge_valid,
  input  wire logic             charge_ready,
  output logic [PCT_W-1:0]      charge_percent
);

  localparam int IDX_W = $clog2(CURVE_POINTS);

  // per-segment constants, segment g runs from point g up to point g-1
  logic [MV_W-1:0]  seg_lo_mv  [CURVE_POINTS];
  logic [MV_W-1:0]  seg_span   [CURVE_POINTS];
  logic [MV_W-2:0]  seg_half   [CURVE_POINTS];
  logic [PCT_W-1:0] seg_lo_pct [CURVE_POINTS];
  logic [PCT_W-1:0] seg_diff   [CURVE_POINTS];
  logic [RCP_W-1:0] seg_rcp    [CURVE_POINTS];
  logic             seg_flat   [CURVE_POINTS];

  for (genvar g = 0; g < CURVE_POINTS; g++) begin : g_seg
    localparam int HI_IDX = (g == 0) ? 0 : g - 1;
    localparam int LO_MV  = int'(OCV_TABLE[g].mv);
    localparam int HI_MV  = int'(OCV_TABLE[HI_IDX].mv);
    localparam int LO_P   = int'(OCV_TABLE[g].pct);
    localparam int HI_P   = int'(OCV_TABLE[HI_IDX].pct);
    localparam bit FLAT   = (g == 0) || (HI_MV <= LO_MV) || (HI_P < LO_P);
    localparam int SPAN   = FLAT ? 1 : HI_MV - LO_MV;
    localparam int DIFF   = FLAT ? 0 : HI_P - LO_P;
    localparam longint RCP = (longint'(1) << RCP_SHIFT) / SPAN;
    localparam int HALF   = SPAN / 2;
    assign seg_lo_mv[g]  = MV_W'(LO_MV);
    assign seg_span[g]   = MV_W'(SPAN);
    assign seg_half[g]   = (MV_W-1)'(HALF);
    assign seg_lo_pct[g] = PCT_W'(LO_P);
    assign seg_diff[g]   = PCT_W'(DIFF);
    assign seg_rcp[g]    = RCP_W'(RCP);
    assign seg_flat[g]   = FLAT;
  end

  // stage advance chain, a stage loads when it is empty or its successor moves
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || charge_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign voltage_ready = adv[0];
  assign charge_valid  = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= voltage_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: compare against every curve point
  logic [MV_W-1:0]         mv1;
  logic [CURVE_POINTS-1:1] ge1;
  logic                    top1;
  logic                    bot1;
  logic [CURVE_POINTS-1:1] ge_a;

  always_comb begin
    for (int i = 1; i < CURVE_POINTS; i++) begin
      ge_a[i] = voltage_mv >= OCV_TABLE[i].mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mv1  <= voltage_mv;
      ge1  <= ge_a;
      top1 <= voltage_mv >= OCV_TABLE[0].mv;
      bot1 <= voltage_mv <= OCV_TABLE[CURVE_POINTS-1].mv;
    end
  end

  // stage 2: first point from the top at or below the voltage
  logic [MV_W-1:0]  mv2;
  logic [IDX_W-1:0] idx2;
  logic             top2;
  logic             bot2;
  logic [IDX_W-1:0] idx_b;

  always_comb begin
    idx_b = '0;
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (ge1[i]) begin
        idx_b = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      mv2  <= mv1;
      idx2 <= idx_b;
      top2 <= top1;
      bot2 <= bot1;
    end
  end

  // stage 3: segment lookup and offset into the segment
  logic [MV_W-1:0]  off3;
  logic [PCT_W-1:0] diff3;
  logic [MV_W-2:0]  half3;
  logic [MV_W-1:0]  span3;
  logic [RCP_W-1:0] rcp3;
  logic [PCT_W-1:0] lopct3;
  logic [1:0]       cls3;
  logic [1:0]       cls_c;

  always_comb begin
    if (top2) begin
      cls_c = CLS_FULL;
    end else if (bot2) begin
      cls_c = CLS_EMPTY;
    end else if (seg_flat[idx2]) begin
      cls_c = CLS_FLAT;
    end else begin
      cls_c = CLS_SEG;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      off3   <= mv2 - seg_lo_mv[idx2];
      diff3  <= seg_diff[idx2];
      half3  <= seg_half[idx2];
      span3  <= seg_span[idx2];
      rcp3   <= seg_rcp[idx2];
      lopct3 <= seg_lo_pct[idx2];
      cls3   <= cls_c;
    end
  end

  // stage 4: numerator, offset times rise plus half the span
  logic [NUM_W-1:0] num4;
  logic [MV_W-1:0]  span4;
  logic [RCP_W-1:0] rcp4;
  logic [PCT_W-1:0] lopct4;
  logic [1:0]       cls4;
  logic [NUM_W-1:0] mul_d;

  assign mul_d = NUM_W'(off3) * NUM_W'(diff3);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      num4   <= mul_d + NUM_W'(half3);
      span4  <= span3;
      rcp4   <= rcp3;
      lopct4 <= lopct3;
      cls4   <= cls3;
    end
  end

  // stage 5: trial quotient by reciprocal, at most one short
  logic [NUM_W-1:0]       num5;
  logic [MV_W-1:0]        span5;
  logic [PCT_W-1:0]       q05;
  logic [PCT_W-1:0]       lopct5;
  logic [1:0]             cls5;
  logic [NUM_W+RCP_W-1:0] prod_e;

  assign prod_e = (NUM_W+RCP_W)'(num4) * (NUM_W+RCP_W)'(rcp4);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      num5   <= num4;
      span5  <= span4;
      q05    <= prod_e[RCP_SHIFT +: PCT_W];
      lopct5 <= lopct4;
      cls5   <= cls4;
    end
  end

  // stage 6: remainder check and quotient correction
  logic [PCT_W-1:0] q6;
  logic [PCT_W-1:0] lopct6;
  logic [1:0]       cls6;
  logic [NUM_W-1:0] qs_f;
  logic [NUM_W-1:0] rem_f;

  assign qs_f  = NUM_W'(q05) * NUM_W'(span5);
  assign rem_f = num5 - qs_f;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      q6     <= q05 + PCT_W'(rem_f >= NUM_W'(span5));
      lopct6 <= lopct5;
      cls6   <= cls5;
    end
  end

  // stage 7: pick the result and limit to full charge
  logic [PCT_W:0]   sum_g;
  logic [PCT_W-1:0] res_g;

  assign sum_g = (PCT_W+1)'(lopct6) + (PCT_W+1)'(q6);

  always_comb begin
    case (cls6)
      CLS_FULL:  res_g = PCT_MAX;
      CLS_EMPTY: res_g = '0;
      CLS_FLAT:  res_g = (lopct6 > PCT_MAX) ? PCT_MAX : lopct6;
      CLS_SEG:   res_g = (sum_g > (PCT_W+1)'(PCT_MAX)) ? PCT_MAX : sum_g[PCT_W-1:0];
      default:   res_g = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      charge_percent <= res_g;
    end
  end

`ifndef NO_ASSERTIONS
  // a delivered charge never exceeds full
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    charge_valid |-> (charge_percent <= PCT_MAX))
    else $error("charge word above full charge");

  // reciprocal quotient is never more than one short
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && (cls5 == CLS_SEG)) |-> (rem_f < (NUM_W'(span5) << 1)))
    else $error("remainder outside two spans");

  // input back-pressure only while the output is held
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !voltage_ready |-> (charge_valid && !charge_ready))
    else $error("input stalled with free output");

  // nothing presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !charge_valid)
    else $error("charge word valid after reset");
`endif

endmodule

`default_nettype wire

@@ tb/battery_voltage_to_charge_percent_test.sv @@
`timescale 1ns / 1ps

module battery_voltage_to_charge_percent_test;
  import bvcp_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int CALM_WORDS   = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 60;

  // own copy of the open-circuit voltage curve, top point first
  localparam int POINT_COUNT = 24;
  localparam int unsigned CURVE_MV [POINT_COUNT] = '{
    4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840, 3820,
    3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3520, 3420, 3300, 3000
  };
  localparam int unsigned CURVE_PCT [POINT_COUNT] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50, 45,
    40, 35, 30, 25, 20, 16, 13, 10, 7, 5, 3, 0
  };

  typedef struct {
    logic [MV_W-1:0]  mv;
    bit               known;
    logic [PCT_W-1:0] pct;
  } probe_t;

  // directed words; known rows carry the charge read straight off the curve
  localparam int PROBE_COUNT = 22;
  probe_t probes [PROBE_COUNT] = '{
    '{16'd0,     1'b1, 7'd0},
    '{16'd65535, 1'b1, 7'd100},
    '{16'd4200,  1'b1, 7'd100},
    '{16'd4201,  1'b1, 7'd100},
    '{16'd3000,  1'b1, 7'd0},
    '{16'd2999,  1'b1, 7'd0},
    '{16'd32768, 1'b1, 7'd100},
    '{16'd21845, 1'b1, 7'd100},
    '{16'd10922, 1'b1, 7'd100},
    '{16'd3001,  1'b0, 7'd0},
    '{16'd4199,  1'b0, 7'd0},
    '{16'd4150,  1'b0, 7'd0},
    '{16'd4175,  1'b0, 7'd0},
    '{16'd3845,  1'b0, 7'd0},
    '{16'd3710,  1'b0, 7'd0},
    '{16'd3700,  1'b0, 7'd0},
    '{16'd3690,  1'b0, 7'd0},
    '{16'd3611,  1'b0, 7'd0},
    '{16'd3609,  1'b0, 7'd0},
    '{16'd3500,  1'b0, 7'd0},
    '{16'd3150,  1'b0, 7'd0},
    '{16'd2048,  1'b1, 7'd0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             voltage_valid = 1'b0;
  logic             voltage_ready;
  logic [MV_W-1:0]  voltage_mv = '0;
  logic             charge_valid;
  logic             charge_ready = 1'b0;
  logic [PCT_W-1:0] charge_percent;

  logic [PCT_W-1:0] pending_charge [$];
  int               fail_count = 0;
  int               cycle_count = 0;
  bit               calm = 1'b0;

  battery_voltage_to_charge_percent dut (
    .clk            (clk),
    .rst            (rst),
    .voltage_valid  (voltage_valid),
    .voltage_ready  (voltage_ready),
    .voltage_mv     (voltage_mv),
    .charge_valid   (charge_valid),
    .charge_ready   (charge_ready),
    .charge_percent (charge_percent)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // piecewise linear charge estimate with rounded division
  function automatic logic [PCT_W-1:0] charge_of_voltage(input logic [MV_W-1:0] mv);
    int unsigned span;
    int unsigned rise;
    int unsigned est;
    int          i;
    if (mv >= CURVE_MV[0]) return PCT_MAX;
    if (mv <= CURVE_MV[POINT_COUNT-1]) return '0;
    for (i = 1; i < POINT_COUNT; i++) begin
      if (mv >= CURVE_MV[i]) begin
        if (CURVE_MV[i-1] <= CURVE_MV[i] || CURVE_PCT[i-1] < CURVE_PCT[i]) begin
          est = CURVE_PCT[i];
        end else begin
          span = CURVE_MV[i-1] - CURVE_MV[i];
          rise = CURVE_PCT[i-1] - CURVE_PCT[i];
          est  = CURVE_PCT[i] + ((mv - CURVE_MV[i]) * rise + span / 2) / span;
        end
        return (est > PCT_MAX) ? PCT_MAX : est[PCT_W-1:0];
      end
    end
    return '0;
  endfunction

  // offer one voltage word, with an occasional idle burst before it
  task automatic offer_voltage(input logic [MV_W-1:0] mv, input bit known,
                               input logic [PCT_W-1:0] pct);
    if (!calm && $urandom_range(0, 4) == 0) begin
      voltage_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    voltage_valid <= 1'b1;
    voltage_mv    <= mv;
    @(posedge clk);
    while (!voltage_ready) @(posedge clk);
    pending_charge.push_back(known ? pct : charge_of_voltage(mv));
  endtask

  task automatic n_stall(inout int seen);
    int len;
    len = $urandom_range(1, 4);
    repeat (len) @(posedge clk);
    seen += len;
  endtask

  task automatic k_run(inout int seen);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    repeat (len) @(posedge clk);
    seen += len;
  endtask

  // sender: directed table, then random words, then drain and verdict
  initial begin
    logic [MV_W-1:0] mv;
    int              k;
    int              n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (k = 0; k < PROBE_COUNT; k++) begin
      offer_voltage(probes[k].mv, probes[k].known, probes[k].pct);
    end
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: mv = MV_W'($urandom_range(0, 65535));
        2: begin
          k  = $urandom_range(0, POINT_COUNT - 1);
          mv = MV_W'(CURVE_MV[k] + $urandom_range(0, 2) - 1);
        end
        default: mv = MV_W'($urandom_range(2950, 4250));
      endcase
      offer_voltage(mv, 1'b0, '0);
    end
    voltage_valid <= 1'b0;
    while (pending_charge.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: short stall bursts, one long hold-off to back the pipeline up
  initial begin
    int  seen;
    bit  held;
    seen = 0;
    held = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!held && seen >= HOLD_START) begin
        held = 1'b1;
        charge_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        seen += HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        charge_ready <= 1'b0;
        n_stall(seen);
      end
      charge_ready <= 1'b1;
      k_run(seen);
    end
  end

  // compare each accepted charge word with the oldest expectation
  always @(posedge clk) begin
    logic [PCT_W-1:0] want;
    if (!rst && charge_valid && charge_ready) begin
      if (pending_charge.size() == 0) begin
        $error("charge_percent: unexpected word, actual %0d", charge_percent);
        fail_count++;
      end else begin
        want = pending_charge.pop_front();
        if (charge_percent !== want) begin
          $error("charge_percent: expected %0d, actual %0d", want, charge_percent);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
